FILE: design/skp_pkg.sv
// ---------------------------------------------------------------------------
// skp_pkg: shared types and constants of the stream-k partition planner
// Job and result records, sequencer states and core count helpers.
// ---------------------------------------------------------------------------
package skp_pkg;

  localparam int MAX_CORES = 1024;
  localparam int CORE_W    = 11;
  localparam int DIVD_W    = 21;
  localparam int DIVS_W    = 27;
  localparam int CNT_W     = 5;

  localparam logic [1:0] ST_PLANNED   = 2'd0;
  localparam logic [1:0] ST_UNCHANGED = 2'd1;
  localparam logic [1:0] ST_NO_FIT    = 2'd2;
  localparam logic [1:0] ST_BAD_SPLIT = 2'd3;

  typedef struct packed {
    logic [15:0] m_tiles;
    logic [15:0] n_tiles;
    logic [15:0] batch_count;
    logic [20:0] k_length;
    logic [12:0] k_tile;
    logic [3:0]  grid_multiple;
    logic [7:0]  prior_split;
    logic        is_scaled;
  } job_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  part_dim;
    logic [13:0] grid_wgs;
    logic [15:0] wave_span;
    logic [15:0] wave_count;
    logic [15:0] tail_blocks;
    logic [13:0] split_factor;
    logic [25:0] k_pad;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MT, S_MA, S_MB, S_MC, S_MD, S_PCHK, S_DIM, S_NEXT,
    S_DIV_GO, S_DIV_WAIT, S_CHK, S_MR, S_MRW, S_MU, S_MUW
  } seq_state_t;

  typedef enum logic [1:0] {
    DK_SPAN, DK_TAIL, DK_SPLIT, DK_PAD
  } div_kind_t;

  function automatic logic [CORE_W-1:0] clamp_cores(input logic [CORE_W-1:0] c);
    logic [CORE_W-1:0] r;
    r = c;
    if (c == '0) r = CORE_W'(1);
    else if (c > CORE_W'(MAX_CORES)) r = CORE_W'(MAX_CORES);
    return r;
  endfunction

  // exact for the clamped core range
  function automatic logic [CORE_W-1:0] div5(input logic [CORE_W-1:0] c);
    logic [CORE_W+13:0] t;
    t = {14'd0, c} * (CORE_W+14)'(3277);
    return t[CORE_W+13:14];
  endfunction

endpackage

FILE: design/skp_div.sv
// ---------------------------------------------------------------------------
// skp_div: restoring divider
// One quotient bit a cycle; gives quotient and remainder with a done pulse.
// ---------------------------------------------------------------------------
module skp_div
  import skp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient,
  output logic [DIVS_W-1:0] remainder
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] quo_r, quo_nxt;
  logic [DIVS_W-1:0] rem_r, rem_nxt;
  logic [DIVS_W-1:0] dvs_r, dvs_nxt;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        quo_nxt = {quo_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: design/skp_seq.sv
// ---------------------------------------------------------------------------
// skp_seq: planning sequencer
// Walks grid sizes and partition dimensions using one multiplier and one divider.
// ---------------------------------------------------------------------------
module skp_seq
  import skp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  job_t              job,
  input  logic [CORE_W-1:0] core_count,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_take,
  output result_t           res
);

  seq_state_t state_r, state_nxt;
  div_kind_t  kind_r;
  job_t       job_r;
  result_t    res_r;
  logic       res_v_r;
  logic [CORE_W-1:0] cores;
  logic [31:0] mul_r;
  logic [15:0] mul_a, mul_b;
  logic [31:0] oth_r [3];
  logic [1:0]  c_r;
  logic [13:0] p_r, minp_r, s_r, split_r;
  logic [15:0] rb_r, waves_r;
  logic [26:0] unit_r;
  logic [DIVD_W-1:0] div_a_r;
  logic [DIVS_W-1:0] div_b_r;
  logic        div_start, div_done;
  logic [DIVD_W-1:0] div_q;
  logic [DIVS_W-1:0] div_rem;
  logic [31:0] oth;
  logic [15:0] blk;
  logic [12:0] ktile;

  assign cores = clamp_cores(core_count);
  assign ktile = (job_r.k_tile == '0) ? 13'd1 : job_r.k_tile;
  assign oth   = oth_r[c_r];

  always_comb begin
    case (c_r)
      2'd0:    blk = job_r.n_tiles;
      2'd1:    blk = job_r.m_tiles;
      default: blk = job_r.batch_count;
    endcase
  end

  skp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a_r),
    .divisor(div_b_r), .done(div_done), .quotient(div_q), .remainder(div_rem)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (job.is_scaled || job.grid_multiple == '0 || job.prior_split != 8'd1)
            state_nxt = S_IDLE;
          else
            state_nxt = S_MT;
        end
      end
      S_MT: state_nxt = S_MA;
      S_MA: state_nxt = S_MB;
      S_MB: state_nxt = S_MC;
      S_MC: state_nxt = S_MD;
      S_MD: state_nxt = S_PCHK;
      S_PCHK: begin
        if (p_r < minp_r || p_r == '0) state_nxt = S_IDLE;
        else state_nxt = S_DIM;
      end
      S_DIM: begin
        if (oth == '0 || oth > {18'd0, p_r}) state_nxt = S_NEXT;
        else state_nxt = S_DIV_GO;
      end
      S_NEXT: state_nxt = (c_r == 2'd2) ? S_PCHK : S_DIM;
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: if (div_done) state_nxt = S_CHK;
      S_CHK: begin
        case (kind_r)
          DK_SPAN: begin
            if (div_rem != '0 || {2'd0, div_q[13:0]} > blk) state_nxt = S_NEXT;
            else state_nxt = S_DIV_GO;
          end
          DK_TAIL:  state_nxt = (div_rem[15:0] == '0) ? S_NEXT : S_MR;
          DK_SPLIT: state_nxt = (div_rem != '0) ? S_NEXT : S_MU;
          DK_PAD:   state_nxt = S_IDLE;
          default:  state_nxt = S_IDLE;
        endcase
      end
      S_MR:  state_nxt = S_MRW;
      S_MRW: state_nxt = S_DIV_GO;
      S_MU:  state_nxt = S_MUW;
      S_MUW: state_nxt = S_DIV_GO;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    case (state_r)
      S_MT: begin
        mul_a = {12'd0, job_r.grid_multiple};
        mul_b = {5'd0, cores};
      end
      S_MA: begin
        mul_a = job_r.batch_count;
        mul_b = job_r.m_tiles;
      end
      S_MB: begin
        mul_a = job_r.batch_count;
        mul_b = job_r.n_tiles;
      end
      S_MC: begin
        mul_a = job_r.m_tiles;
        mul_b = job_r.n_tiles;
      end
      S_MR: begin
        mul_a = rb_r;
        mul_b = oth[15:0];
      end
      S_MU: begin
        mul_a = {2'd0, split_r};
        mul_b = {3'd0, ktile};
      end
      S_DIV_GO: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      res_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_take) res_v_r <= 1'b0;
      if ((state_r == S_PCHK && state_nxt == S_IDLE) ||
          (state_r == S_CHK && kind_r == DK_PAD) ||
          (state_r == S_IDLE && start && state_nxt == S_IDLE))
        res_v_r <= 1'b1;
    end
    mul_r <= {16'd0, mul_a} * {16'd0, mul_b};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          job_r <= job;
          res_r <= '0;
          if (job.is_scaled || job.grid_multiple == '0) res_r.status <= ST_UNCHANGED;
          else if (job.prior_split != 8'd1) res_r.status <= ST_BAD_SPLIT;
        end
      end
      S_MA: begin
        p_r    <= mul_r[13:0];
        minp_r <= mul_r[13:0] - {3'd0, div5(cores)};
      end
      S_MB: oth_r[0] <= mul_r;
      S_MC: oth_r[1] <= mul_r;
      S_MD: begin
        oth_r[2] <= mul_r;
        c_r      <= 2'd0;
      end
      S_PCHK: begin
        c_r <= 2'd0;
        if (p_r < minp_r || p_r == '0) res_r.status <= ST_NO_FIT;
      end
      S_DIM: begin
        kind_r  <= DK_SPAN;
        div_a_r <= {7'd0, p_r};
        div_b_r <= {13'd0, oth[13:0]};
      end
      S_NEXT: begin
        if (c_r == 2'd2) begin
          c_r <= 2'd0;
          p_r <= p_r - 14'd1;
        end else begin
          c_r <= c_r + 2'd1;
        end
      end
      S_CHK: begin
        case (kind_r)
          DK_SPAN: begin
            s_r     <= div_q[13:0];
            kind_r  <= DK_TAIL;
            div_a_r <= {5'd0, blk};
            div_b_r <= {13'd0, div_q[13:0]};
          end
          DK_TAIL: begin
            rb_r    <= div_rem[15:0];
            waves_r <= div_q[15:0];
          end
          DK_SPLIT: split_r <= div_q[13:0];
          DK_PAD: begin
            res_r.status       <= ST_PLANNED;
            res_r.part_dim     <= 2'd2 - c_r;
            res_r.grid_wgs     <= p_r;
            res_r.wave_span    <= {2'd0, s_r};
            res_r.wave_count   <= waves_r;
            res_r.tail_blocks  <= rb_r;
            res_r.split_factor <= split_r;
            res_r.k_pad        <= (div_rem == '0) ? 26'd0 : 26'(unit_r - div_rem);
          end
          default: ;
        endcase
      end
      S_MRW: begin
        kind_r  <= DK_SPLIT;
        div_a_r <= {7'd0, p_r};
        div_b_r <= mul_r[26:0];
      end
      S_MUW: begin
        kind_r  <= DK_PAD;
        unit_r  <= mul_r[26:0];
        div_a_r <= job_r.k_length;
        div_b_r <= mul_r[26:0];
      end
      default: ;
    endcase
  end

  assign idle      = (state_r == S_IDLE) && !res_v_r;
  assign res_valid = res_v_r;
  assign res       = res_r;

endmodule

FILE: design/stream_k_partition_planner_top.sv
// ---------------------------------------------------------------------------
// stream_k_partition_planner_top: stream-k hybrid partition planner
// Plans grid size, partition dimension and split-k tail for one GEMM job.
// ---------------------------------------------------------------------------
// usage
//   a request is taken on the in_ channel when in_valid is high and in_stall
//   low; one result follows on the out_ channel, held until out_stall is low.
//   core_count is written through the apb port at address 0 while idle.
// sequence
//   a request that skips planning sets the sequencer's result valid as it is
//   taken; the result then moves into the output register once it is free.
//   a planned request runs the multiply states S_MT to S_MD, then checks at
//   most core_count/5 + 1 grid sizes; a dimension is dropped via S_DIM and
//   S_NEXT or runs the shared restoring divider (start, DIVD_W quotient bits,
//   done, check) for its span, tail, split and pad divides in turn.
// throughput
//   one request at a time; in_stall stays high from acceptance until the
//   result has moved into the output register.
// reset
//   rst_n low clears the sequencer state, its result valid and the output valid; core_count returns to 1.
// stall
//   a waiting result holds the output register and the sequencer; a new
//   request is taken once the result has been handed on.
// ---------------------------------------------------------------------------
module stream_k_partition_planner_top
  import skp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_m_tiles,
  input  logic [15:0] in_n_tiles,
  input  logic [15:0] in_batch_count,
  input  logic [20:0] in_k_length,
  input  logic [12:0] in_k_tile,
  input  logic [3:0]  in_grid_multiple,
  input  logic [7:0]  in_prior_split,
  input  logic        in_is_scaled,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [1:0]  out_part_dim,
  output logic [13:0] out_grid_wgs,
  output logic [15:0] out_wave_span,
  output logic [15:0] out_wave_count,
  output logic [15:0] out_tail_blocks,
  output logic [13:0] out_split_factor,
  output logic [25:0] out_k_pad,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CORE_W-1:0] core_count_r;
  logic              out_valid_r;
  result_t           out_r;
  job_t              job;
  result_t           res;
  logic              seq_idle, res_valid, res_take, start;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {21'd0, core_count_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_count_r <= CORE_W'(1);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      core_count_r <= pwdata[CORE_W-1:0];
    end
  end

  assign job = '{m_tiles: in_m_tiles, n_tiles: in_n_tiles, batch_count: in_batch_count,
                 k_length: in_k_length, k_tile: in_k_tile,
                 grid_multiple: in_grid_multiple, prior_split: in_prior_split,
                 is_scaled: in_is_scaled};

  assign in_stall = !seq_idle;
  assign start    = in_valid && seq_idle;
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  skp_seq u_seq (
    .clk(clk), .rst_n(rst_n), .start(start), .job(job), .core_count(core_count_r),
    .idle(seq_idle), .res_valid(res_valid), .res_take(res_take), .res(res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) out_r <= res;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_r.status;
  assign out_part_dim     = out_r.part_dim;
  assign out_grid_wgs     = out_r.grid_wgs;
  assign out_wave_span    = out_r.wave_span;
  assign out_wave_count   = out_r.wave_count;
  assign out_tail_blocks  = out_r.tail_blocks;
  assign out_split_factor = out_r.split_factor;
  assign out_k_pad        = out_r.k_pad;

endmodule

FILE: bench/stream_k_partition_planner_top_tb.sv
// ---------------------------------------------------------------------------
// stream_k_partition_planner_top_tb: self-checking bench for the planner
// Drives jobs with random gaps, predicts each plan and compares all fields.
// ---------------------------------------------------------------------------
module stream_k_partition_planner_top_tb;
  import skp_pkg::*;

  class plan_board;
    result_t plans_due[$];
    int errors;
    logic [10:0] cores_reg;

    function new();
      errors = 0;
      cores_reg = 11'd1;
    endfunction

    function result_t plan_job(job_t j);
      result_t r;
      longint unsigned cores, target, minp, p, kt, s, rb, rem, split, unit;
      longint unsigned blk[3], oth[3];
      int dimc[3];
      r = '0;
      if (j.is_scaled || j.grid_multiple == 0) begin
        r.status = ST_UNCHANGED;
        return r;
      end
      if (j.prior_split != 8'd1) begin
        r.status = ST_BAD_SPLIT;
        return r;
      end
      cores = cores_reg;
      if (cores == 0) cores = 1;
      if (cores > MAX_CORES) cores = MAX_CORES;
      kt = j.k_tile;
      if (kt == 0) kt = 1;
      target = j.grid_multiple * cores;
      minp = target - cores / 5;
      dimc[0] = 2; blk[0] = j.n_tiles; oth[0] = j.batch_count * j.m_tiles;
      dimc[1] = 1; blk[1] = j.m_tiles; oth[1] = j.batch_count * j.n_tiles;
      dimc[2] = 0; blk[2] = j.batch_count; oth[2] = j.m_tiles * j.n_tiles;
      for (p = target; p >= minp && p > 0; p--) begin
        for (int c = 0; c < 3; c++) begin
          if (oth[c] == 0 || p % oth[c] != 0) continue;
          s = p / oth[c];
          if (s == 0 || s > blk[c]) continue;
          rb = blk[c] % s;
          if (rb == 0) continue;
          rem = rb * oth[c];
          if (p % rem != 0) continue;
          split = p / rem;
          unit = split * kt;
          r.status = ST_PLANNED;
          r.part_dim = 2'(dimc[c]);
          r.grid_wgs = 14'(p);
          r.wave_span = 16'(s);
          r.wave_count = 16'(blk[c] / s);
          r.tail_blocks = 16'(rb);
          r.split_factor = 14'(split);
          r.k_pad = 26'((unit - j.k_length % unit) % unit);
          return r;
        end
      end
      r.status = ST_NO_FIT;
      return r;
    endfunction

    function void note_request(job_t j);
      plans_due.insert(plans_due.size(), plan_job(j));
    endfunction

    function void check_plan(result_t a);
      result_t e;
      if (plans_due.size() == 0) begin
        $error("unexpected result status %0d", a.status);
        errors++;
        return;
      end
      e = plans_due.pop_front();
      if (a.status != e.status) begin
        $error("status exp %0d got %0d", e.status, a.status); errors++;
      end
      if (a.part_dim != e.part_dim) begin
        $error("part_dim exp %0d got %0d", e.part_dim, a.part_dim); errors++;
      end
      if (a.grid_wgs != e.grid_wgs) begin
        $error("grid_wgs exp %0d got %0d", e.grid_wgs, a.grid_wgs); errors++;
      end
      if (a.wave_span != e.wave_span) begin
        $error("wave_span exp %0d got %0d", e.wave_span, a.wave_span); errors++;
      end
      if (a.wave_count != e.wave_count) begin
        $error("wave_count exp %0d got %0d", e.wave_count, a.wave_count); errors++;
      end
      if (a.tail_blocks != e.tail_blocks) begin
        $error("tail_blocks exp %0d got %0d", e.tail_blocks, a.tail_blocks); errors++;
      end
      if (a.split_factor != e.split_factor) begin
        $error("split_factor exp %0d got %0d", e.split_factor, a.split_factor);
        errors++;
      end
      if (a.k_pad != e.k_pad) begin
        $error("k_pad exp %0d got %0d", e.k_pad, a.k_pad); errors++;
      end
    endfunction
  endclass

  localparam logic [2:0] ADDR_CORES = 3'd0;
  localparam longint LIMIT = 64'd20000000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  job_t job = '0;
  logic out_valid;
  logic out_stall = 1;
  result_t res;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  plan_board board;
  int idle_pct = 27;
  bit hold_rx = 0;
  longint cycles = 0;

  always #1 clk = ~clk;

  stream_k_partition_planner_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_m_tiles(job.m_tiles), .in_n_tiles(job.n_tiles),
    .in_batch_count(job.batch_count), .in_k_length(job.k_length),
    .in_k_tile(job.k_tile), .in_grid_multiple(job.grid_multiple),
    .in_prior_split(job.prior_split), .in_is_scaled(job.is_scaled),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(res.status), .out_part_dim(res.part_dim),
    .out_grid_wgs(res.grid_wgs), .out_wave_span(res.wave_span),
    .out_wave_count(res.wave_count), .out_tail_blocks(res.tail_blocks),
    .out_split_factor(res.split_factor), .out_k_pad(res.k_pad),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial board = new();

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stall, check on every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_plan(res);
    if (hold_rx) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < idle_pct);
  end

  task automatic write_cores(logic [10:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= ADDR_CORES; pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.cores_reg = v;
  endtask

  task automatic send_job(job_t j);
    @(posedge clk);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    in_valid <= 1;
    job <= j;
    do @(posedge clk); while (in_stall);
    board.note_request(j);
    in_valid <= 0;
  endtask

  task automatic drain();
    while (board.plans_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic job_t planned_job();
    job_t j;
    j.m_tiles = 16'($urandom_range(1, 12));
    j.n_tiles = 16'($urandom_range(1, 40));
    j.batch_count = 16'($urandom_range(1, 4));
    j.k_tile = 13'($urandom_range(1, 64));
    j.k_length = 21'($urandom_range(1, 2097151));
    j.grid_multiple = 4'($urandom_range(1, 4));
    j.prior_split = 8'd1;
    j.is_scaled = 1'b0;
    return j;
  endfunction

  function automatic job_t noise_job();
    job_t j;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    j = raw[$bits(job_t)-1:0];
    return j;
  endfunction

  initial begin
    job_t j;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed, default core count
    j = planned_job(); send_job(j);
    j.is_scaled = 1; send_job(j);
    j = planned_job(); j.grid_multiple = 0; send_job(j);
    j = planned_job(); j.prior_split = 8'd255; send_job(j);
    j = planned_job(); j.prior_split = 8'd0; send_job(j);
    drain();
    write_cores(11'd20);
    j = planned_job(); j.m_tiles = 1; j.n_tiles = 7; j.batch_count = 1;
    j.grid_multiple = 1; send_job(j);
    j.m_tiles = 0; send_job(j);
    j.k_tile = 0; j.m_tiles = 1; send_job(j);
    j = planned_job(); j.m_tiles = 16'hffff; j.n_tiles = 16'hffff;
    j.batch_count = 16'hffff; j.k_length = 21'h1fffff; j.k_tile = 13'h1fff;
    j.grid_multiple = 4'hf; send_job(j);
    j.batch_count = 0; send_job(j);
    drain();
    write_cores(11'd0);
    j = planned_job(); send_job(j);
    drain();
    write_cores(11'h7ff);
    j = planned_job(); j.grid_multiple = 4'hf; j.n_tiles = 16'd15000; send_job(j);
    j = planned_job(); j.m_tiles = 1; j.batch_count = 1; j.n_tiles = 1500;
    send_job(j);
    drain();
    write_cores(11'd1024);
    j = planned_job(); j.m_tiles = 1; j.batch_count = 1; j.n_tiles = 16'd1500;
    j.grid_multiple = 1; send_job(j);
    drain();
    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_rx = 1;
        repeat (400) @(posedge clk);
        hold_rx = 0;
      end
      for (int i = 0; i < 3; i++) begin
        j = planned_job(); j.is_scaled = 1; send_job(j);
      end
    join
    drain();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_cores(11'd1);
        1: write_cores(11'($urandom_range(2, 64)));
        2: write_cores(11'($urandom_range(65, 2047)));
        default: write_cores(11'($urandom_range(5, 30)));
      endcase
      idle_pct = (phase == 2) ? 0 : 27;
      for (int i = 0; i < 32; i++) begin
        if ($urandom_range(99) < 80) j = planned_job();
        else j = noise_job();
        if (phase == 2 && j.grid_multiple > 2) j.grid_multiple = 2;
        send_job(j);
      end
      drain();
    end
    if (board.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
